[hdl/vic_pkg.sv]
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types, codes and sizes for the VLAN ingress classifier.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int PORT_COUNT  = 16;

  localparam int IDX_W  = 4;
  localparam int PORT_W = 4;
  localparam int TAG_W  = 16;
  localparam int MODE_W = 2;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [TAG_W-1:0] TPID_8021Q = 16'h8100;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  // entry modes
  localparam logic [MODE_W-1:0] MODE_DISABLED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MATCH_TAG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNTAGGED  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CATCH_ALL = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_DELIVERED = 2'd0;
  localparam logic [ST_W-1:0] ST_DROPPED   = 2'd1;
  localparam logic [ST_W-1:0] ST_WRITTEN   = 2'd2;
  localparam logic [ST_W-1:0] ST_READ      = 2'd3;

  // One word in flight along the cell chain, with its running search state.
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [PORT_W-1:0] rx_port;
    logic              port_ok;
    logic              is_tagged;
    logic [TAG_W-1:0]  tci;
    logic [IDX_W-1:0]  idx;
    logic [MODE_W-1:0] emode;
    logic [PORT_W-1:0] eport;
    logic [TAG_W-1:0]  etag;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              have_other;
    logic [IDX_W-1:0]  other_idx;
    logic [MODE_W-1:0] rd_mode;
    logic [PORT_W-1:0] rd_port;
    logic [TAG_W-1:0]  rd_tag;
  } vic_tok_t;

endpackage

[hdl/vic_cell.sv]
// ----------------------------------------------------------------------------
// vic_cell
// One table entry plus one chain stage: match, write or read the entry as a
// word passes, then hand the word to the next lower entry.
// ----------------------------------------------------------------------------
module vic_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic [vic_pkg::IDX_W-1:0] cell_idx,
  input  vic_pkg::vic_tok_t       tok_in,
  output vic_pkg::vic_tok_t       tok_out
);
  import vic_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [TAG_W-1:0]  tag_r,  tag_nxt;
  vic_tok_t          tok_r,  tok_nxt;

  logic sel;
  logic on_port;
  logic match;

  always_comb begin
    sel     = tok_in.valid && (tok_in.idx == cell_idx);
    on_port = tok_in.port_ok && (mode_r != MODE_DISABLED) && (port_r == tok_in.rx_port);
    match   = on_port &&
              (((mode_r == MODE_MATCH_TAG) && tok_in.is_tagged && (tag_r == tok_in.tci)) ||
               ((mode_r == MODE_UNTAGGED) && !tok_in.is_tagged));

    mode_nxt = mode_r;
    port_nxt = port_r;
    tag_nxt  = tag_r;
    tok_nxt  = tok_in;

    case (tok_in.op)
      OP_CLASSIFY: begin
        if (!tok_in.hit) begin
          if (match) begin
            tok_nxt.hit     = 1'b1;
            tok_nxt.hit_idx = cell_idx;
          end else if (on_port && (mode_r == MODE_CATCH_ALL)) begin
            // lower entries come later, so the last one seen wins
            tok_nxt.have_other = 1'b1;
            tok_nxt.other_idx  = cell_idx;
          end
        end
      end
      OP_WRITE: begin
        if (sel) begin
          mode_nxt = tok_in.emode;
          port_nxt = tok_in.eport;
          tag_nxt  = tok_in.etag;
        end
      end
      OP_READ: begin
        if (sel) begin
          tok_nxt.rd_mode = mode_r;
          tok_nxt.rd_port = port_r;
          tok_nxt.rd_tag  = tag_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DISABLED;
      port_r <= '0;
      tag_r  <= '0;
      tok_r  <= '0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      port_r <= port_nxt;
      tag_r  <= tag_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

[hdl/vlan_ingress_classifier.sv]
// ----------------------------------------------------------------------------
// vlan_ingress_classifier
// 802.1Q receive-side tag classifier built as a chain of table-entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one word per request. in_tuser carries the operation
//   (classify a frame header, write an entry, read an entry); in_tdata carries
//   the header bytes 12..15, the receiving port and the entry fields.
//   Output stream (out_*): exactly one word per request, in request order.
//   out_tuser carries the status, out_tdata the index, tag and entry fields.
//   Each request walks the cell chain from the highest entry down to entry 0,
//   one cell at a time, then passes the output register before out_tvalid.
//   Requests are pipelined: a new word is accepted every cycle unless the
//   output stalls; the chain length does not limit the rate.
//   Writes and reads take effect as the word passes its entry's cell, so
//   every request sees the table exactly as left by all earlier requests.
//   Reset: synchronous, active low; clears every entry to disabled, port 0,
//   tag 0 and empties the chain. No clearing pass is needed.
//   Stall: when out_tvalid is high and out_tready low, the whole chain
//   freezes and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vlan_ingress_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  // [3:0] rx_port, [19:4] frame_ethertype, [35:20] frame_tci,
  // [39:36] entry_index, [41:40] entry_mode, [45:42] entry_port,
  // [61:46] entry_tag, [63:62] zero
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status
  output logic [1:0]  out_tuser,
  // [3:0] vlan_index, [4] tag_stripped, [20:5] found_tag,
  // [22:21] read_mode, [26:23] read_port, [31:27] zero
  output logic [31:0] out_tdata
);
  import vic_pkg::*;

  logic     adv;
  vic_tok_t head;
  vic_tok_t chain [ENTRY_COUNT+1];

  logic              out_valid_r;
  logic [ST_W-1:0]   status_r,   status_nxt;
  logic [IDX_W-1:0]  vidx_r,     vidx_nxt;
  logic              strip_r,    strip_nxt;
  logic [TAG_W-1:0]  ftag_r,     ftag_nxt;
  logic [MODE_W-1:0] rmode_r,    rmode_nxt;
  logic [PORT_W-1:0] rport_r,    rport_nxt;

  vic_tok_t tail;

  // advance the whole chain whenever the output register can take a word
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // unpack the request and seed the search state
  always_comb begin
    head            = '0;
    head.valid      = in_tvalid;
    head.op         = in_tuser;
    head.rx_port    = in_tdata[3:0];
    head.port_ok    = (32'(in_tdata[3:0]) < PORT_COUNT);
    head.is_tagged  = (in_tdata[19:4] == TPID_8021Q);
    head.tci        = in_tdata[35:20];
    head.idx        = in_tdata[39:36];
    head.emode      = in_tdata[41:40];
    head.eport      = in_tdata[45:42];
    head.etag       = in_tdata[61:46];
  end

  assign chain[0] = head;

  // cell k holds entry ENTRY_COUNT-1-k: highest entry first
  for (genvar k = 0; k < ENTRY_COUNT; k++) begin : g_cell
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(ENTRY_COUNT - 1 - k);
    vic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (CELL_IDX),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  assign tail = chain[ENTRY_COUNT];

  // form the result from the word leaving entry 0
  always_comb begin
    status_nxt = ST_DROPPED;
    vidx_nxt   = '0;
    strip_nxt  = 1'b0;
    ftag_nxt   = '0;
    rmode_nxt  = '0;
    rport_nxt  = '0;
    case (tail.op)
      OP_CLASSIFY: begin
        strip_nxt = tail.is_tagged;
        ftag_nxt  = tail.is_tagged ? tail.tci : '0;
        if (tail.hit) begin
          status_nxt = ST_DELIVERED;
          vidx_nxt   = tail.hit_idx;
        end else if (tail.have_other) begin
          // fall back to the lowest catch-all entry on the port
          status_nxt = ST_DELIVERED;
          vidx_nxt   = tail.other_idx;
        end
      end
      OP_WRITE: begin
        status_nxt = ST_WRITTEN;
        vidx_nxt   = tail.idx;
      end
      OP_READ: begin
        status_nxt = ST_READ;
        vidx_nxt   = tail.idx;
        ftag_nxt   = tail.rd_tag;
        rmode_nxt  = tail.rd_mode;
        rport_nxt  = tail.rd_port;
      end
      default: begin
        // unknown operation: answer dropped with all fields zero
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      vidx_r   <= vidx_nxt;
      strip_r  <= strip_nxt;
      ftag_r   <= ftag_nxt;
      rmode_r  <= rmode_nxt;
      rport_r  <= rport_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {5'b0, rport_r, rmode_r, ftag_r, strip_r, vidx_r};

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VLAN ingress classifier. A scoreboard keeps its
// own copy of the entry table, predicts the answer to every accepted request
// word and checks each answer word against the oldest prediction. Directed
// words cover the lookup rules first; random phases with varied idling on
// both streams follow.
// ----------------------------------------------------------------------------
module tb_top;
  import vic_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = ENTRY_COUNT + 8;
  localparam int PRINT_CAP    = 30;

  // operation code the block does not define
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  tag;
  } vlan_entry_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  vlan_index;
    logic              tag_stripped;
    logic [TAG_W-1:0]  found_tag;
    logic [MODE_W-1:0] read_mode;
    logic [PORT_W-1:0] read_port;
  } vlan_answer_t;

  // Scoreboard: table copy, predicted answers in request order, error count.
  class vlan_scoreboard;
    vlan_entry_t  entries [ENTRY_COUNT];
    vlan_answer_t answers_due [$];
    int           errors;

    function new();
      foreach (entries[i]) entries[i] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    function int pending();
      return answers_due.size();
    endfunction

    // Walk the table for one request and apply any write.
    function vlan_answer_t lookup_and_update(logic [OP_W-1:0] op, logic [63:0] d);
      vlan_answer_t      a;
      logic [PORT_W-1:0] rx;
      logic [TAG_W-1:0]  etype;
      logic [TAG_W-1:0]  tci;
      logic [IDX_W-1:0]  idx;
      logic              is_tagged;
      logic              hit;
      logic              have_other;
      logic [IDX_W-1:0]  hit_i;
      logic [IDX_W-1:0]  other_i;
      vlan_entry_t       e;
      rx    = d[3:0];
      etype = d[19:4];
      tci   = d[35:20];
      idx   = d[39:36];
      a     = '0;
      case (op)
        OP_CLASSIFY: begin
          is_tagged  = (etype == TPID_8021Q);
          hit        = 1'b0;
          have_other = 1'b0;
          hit_i      = '0;
          other_i    = '0;
          if (rx < PORT_COUNT) begin
            for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
              e = entries[i];
              if (!hit && e.mode != MODE_DISABLED && e.port == rx) begin
                if ((e.mode == MODE_MATCH_TAG && is_tagged && e.tag == tci) ||
                    (e.mode == MODE_UNTAGGED && !is_tagged)) begin
                  hit   = 1'b1;
                  hit_i = IDX_W'(i);
                end else if (e.mode == MODE_CATCH_ALL) begin
                  have_other = 1'b1;
                  other_i    = IDX_W'(i);
                end
              end
            end
          end
          if (!hit && have_other) begin
            hit   = 1'b1;
            hit_i = other_i;
          end
          a.status       = hit ? ST_DELIVERED : ST_DROPPED;
          a.vlan_index   = hit ? hit_i : '0;
          a.tag_stripped = is_tagged;
          a.found_tag    = is_tagged ? tci : '0;
        end
        OP_WRITE: begin
          if (idx < ENTRY_COUNT) begin
            entries[idx].mode = d[41:40];
            entries[idx].port = d[45:42];
            entries[idx].tag  = d[61:46];
          end
          a.status     = ST_WRITTEN;
          a.vlan_index = idx;
        end
        OP_READ: begin
          a.status     = ST_READ;
          a.vlan_index = idx;
          if (idx < ENTRY_COUNT) begin
            a.found_tag = entries[idx].tag;
            a.read_mode = entries[idx].mode;
            a.read_port = entries[idx].port;
          end
        end
        default: begin
          a.status = ST_DROPPED;
        end
      endcase
      return a;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [63:0] d);
      answers_due.push_back(lookup_and_update(op, d));
    endfunction

    task check_answer(logic [ST_W-1:0] st, logic [31:0] d);
      vlan_answer_t x;
      if (answers_due.size() == 0) begin
        report($sformatf("answer with no request pending: status %0d data %h", st, d));
        return;
      end
      x = answers_due.pop_front();
      if (st != x.status)
        report($sformatf("status got %0d exp %0d", st, x.status));
      if (d[3:0] != x.vlan_index)
        report($sformatf("vlan_index got %0d exp %0d", d[3:0], x.vlan_index));
      if (d[4] != x.tag_stripped)
        report($sformatf("tag_stripped got %0b exp %0b", d[4], x.tag_stripped));
      if (d[20:5] != x.found_tag)
        report($sformatf("found_tag got %h exp %h", d[20:5], x.found_tag));
      if (d[22:21] != x.read_mode)
        report($sformatf("read_mode got %0d exp %0d", d[22:21], x.read_mode));
      if (d[26:23] != x.read_port)
        report($sformatf("read_port got %0d exp %0d", d[26:23], x.read_port));
      if (d[31:27] != '0)
        report($sformatf("pad bits got %b", d[31:27]));
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [31:0] out_tdata;

  vlan_scoreboard sb = new();

  int cycles     = 0;
  int idle_level = 1;   // 0 no idling, 1 light, 2 heavy
  int stall_left = 0;

  logic [TAG_W-1:0]  tag_pool  [6];
  logic [PORT_W-1:0] port_pool [3];

  vlan_ingress_classifier u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run as a failure once the cycle limit is passed.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check every answer word at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_answer(out_tuser, out_tdata);
  end

  // Idle length: mostly zero or short, now and then long.
  function automatic int pick_gap(int level);
    int r;
    r = $urandom_range(0, 99);
    if (level == 0) return 0;
    if (level == 1) begin
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
    end
    if (r < 30) return 0;
    if (r < 80) return $urandom_range(1, 4);
    return $urandom_range(6, 40);
  endfunction

  // Receiver back-pressure: hold ready low for a random stretch, then release.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready = 1'b1;
      stall_left = pick_gap(idle_level);
    end
  end

  function automatic logic [63:0] pack_req(logic [3:0] rx, logic [15:0] etype,
                                           logic [15:0] tci, logic [3:0] idx,
                                           logic [1:0] mode, logic [3:0] port,
                                           logic [15:0] tag);
    return {2'b00, tag, port, mode, idx, tci, etype, rx};
  endfunction

  // Present one request word after a random gap and hold it until accepted.
  task automatic send_word(logic [OP_W-1:0] op, logic [63:0] d);
    int n;
    n = pick_gap(idle_level);
    repeat (n) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = {$urandom(), $urandom()} & 64'h3fff_ffff_ffff_ffff;
      in_tuser  = 2'($urandom_range(0, 3));
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, d);
  endtask

  task automatic do_write(logic [3:0] idx, logic [1:0] mode, logic [3:0] port,
                          logic [15:0] tag);
    send_word(OP_WRITE, pack_req('0, '0, '0, idx, mode, port, tag));
  endtask

  task automatic do_read(logic [3:0] idx);
    send_word(OP_READ, pack_req('0, '0, '0, idx, '0, '0, '0));
  endtask

  task automatic do_classify(logic [3:0] rx, logic [15:0] etype, logic [15:0] tci);
    send_word(OP_CLASSIFY, pack_req(rx, etype, tci, '0, '0, '0, '0));
  endtask

  // Drop valid and hold off until every predicted answer has come back.
  task automatic wait_all_answered();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [PORT_W-1:0] pick_port();
    if ($urandom_range(0, 99) < 80) return port_pool[$urandom_range(0, 2)];
    return PORT_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 99) < 75) return tag_pool[$urandom_range(0, 5)];
    return TAG_W'($urandom_range(0, 65535));
  endfunction

  task automatic refresh_pools();
    foreach (port_pool[i]) port_pool[i] = PORT_W'($urandom_range(0, 15));
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom_range(0, 65535));
    tag_pool[0] = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
  endtask

  // Random words: mostly lookups against entries on a few busy ports/tags.
  task automatic send_random(int count);
    int          r;
    logic [15:0] etype;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        do_write(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), pick_port(),
                 pick_tag());
      end else if (r < 32) begin
        do_read(4'($urandom_range(0, 15)));
      end else if (r < 95) begin
        r = $urandom_range(0, 99);
        if (r < 60)      etype = TPID_8021Q;
        else if (r < 72) etype = TPID_8021Q ^ (16'h1 << $urandom_range(0, 15));
        else             etype = 16'($urandom_range(0, 65535));
        do_classify(pick_port(), etype,
                    ($urandom_range(0, 99) < 70) ? pick_tag() :
                                                   16'($urandom_range(0, 65535)));
      end else begin
        send_word(OP_UNDEF, {$urandom(), $urandom()} & 64'h3fff_ffff_ffff_ffff);
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, then a layered table on port 0.
    idle_level = 1;
    do_read(4'd0);
    do_read(4'd15);
    do_classify(4'd0, 16'h0800, 16'h0000);
    do_classify(4'd0, TPID_8021Q, 16'h0001);
    do_write(4'd15, MODE_MATCH_TAG, 4'd15, 16'hffff);
    do_write(4'd0,  MODE_CATCH_ALL, 4'd0, 16'h0000);
    do_write(4'd3,  MODE_UNTAGGED,  4'd0, 16'h5555);
    do_write(4'd7,  MODE_MATCH_TAG, 4'd0, 16'h0000);
    do_write(4'd9,  MODE_CATCH_ALL, 4'd0, 16'haaaa);
    do_write(4'd12, MODE_DISABLED,  4'd0, 16'h1234);
    do_classify(4'd0, TPID_8021Q, 16'h0000);   // tag match beats catch-all
    do_classify(4'd0, TPID_8021Q, 16'h1234);   // disabled ignored, lowest catch-all
    do_classify(4'd0, 16'h0800, 16'h1234);     // untagged entry
    do_classify(4'd0, 16'h8101, 16'h0000);     // near-miss ethertype is untagged
    do_classify(4'd0, 16'h0081, 16'hffff);
    do_classify(4'd15, TPID_8021Q, 16'hffff);
    do_classify(4'd15, TPID_8021Q, 16'hfffe);  // no match, no catch-all: drop
    do_classify(4'd15, 16'hffff, 16'hffff);    // untagged, no untagged entry: drop
    do_classify(4'd5, TPID_8021Q, 16'h0000);   // port with no entries
    send_word(OP_UNDEF, 64'h3fff_ffff_ffff_ffff);  // unknown operation
    do_read(4'd7);
    do_read(4'd12);
    do_write(4'd15, MODE_CATCH_ALL, 4'd15, 16'hffff);
    do_read(4'd15);
    do_classify(4'd15, TPID_8021Q, 16'h0000);
    wait_all_answered();

    // Random phases: no idling, heavy idling, then light idling.
    for (int p = 0; p < 4; p++) begin
      refresh_pools();
      idle_level = (p == 0) ? 0 : (p == 1) ? 2 : 1;
      send_random(150);
      if (p == 2) wait_all_answered();
      send_random(140);
      wait_all_answered();
    end

    if (sb.pending() != 0) sb.report($sformatf("%0d answers never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/vic_pkg.sv
hdl/vic_cell.sv
hdl/vlan_ingress_classifier.sv
test/tb_top.sv
